// ===== sv/imufps_pkg.sv =====
// Shared types, constants and the scaling function for the IMU frame parser and scaler.
`timescale 1ns / 1ps
`default_nettype none

package imufps_pkg;

  localparam int unsigned MAX_FRAME_LENGTH = 32;
  localparam int unsigned MIN_FRAME_LENGTH = 10;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned POS_W = $clog2(MAX_FRAME_LENGTH);
  localparam int unsigned MULT_W = 25;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(11);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_FRAME_LENGTH);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_LENGTH);

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_TIME   = 8'h50;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [7:0] TYPE_MAG    = 8'h54;
  localparam logic [7:0] TYPE_QUAT   = 8'h59;

  localparam logic [2:0] KIND_TIME  = 3'd0;
  localparam logic [2:0] KIND_ACCEL = 3'd1;
  localparam logic [2:0] KIND_GYRO  = 3'd2;
  localparam logic [2:0] KIND_ANGLE = 3'd3;
  localparam logic [2:0] KIND_MAG   = 3'd4;
  localparam logic [2:0] KIND_QUAT  = 3'd5;

  localparam logic [MULT_W-1:0] MULT_ACCEL = MULT_W'(20552090);
  localparam logic [MULT_W-1:0] MULT_GYRO  = MULT_W'(4575276);
  localparam logic [MULT_W-1:0] MULT_ANGLE = MULT_W'(411775);
  localparam logic [MULT_W-1:0] MULT_QUAT  = MULT_W'(131072);

  typedef logic [7:0][7:0] payload_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_burst;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] raw_word0;
    logic signed [15:0] raw_word1;
    logic signed [15:0] raw_word2;
    logic signed [15:0] raw_word3;
    logic signed [31:0] scaled0;
    logic signed [31:0] scaled1;
    logic signed [31:0] scaled2;
    logic signed [31:0] scaled3;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    payload_t   payload;
  } frame_t;

  function automatic logic [31:0] scale_word(input logic [15:0] raw, input logic [2:0] kind);
    logic [MULT_W-1:0] mult;
    logic [15:0]       mag;
    logic [40:0]       prod;
    logic [40:0]       rounded;
    logic [24:0]       q;
    logic [31:0]       res;
    case (kind)
      KIND_ACCEL: mult = MULT_ACCEL;
      KIND_GYRO:  mult = MULT_GYRO;
      KIND_ANGLE: mult = MULT_ANGLE;
      KIND_QUAT:  mult = MULT_QUAT;
      default:    mult = '0;
    endcase
    mag = raw[15] ? 16'(-raw) : raw;
    prod = 41'(mag) * 41'(mult);
    rounded = prod + 41'h8000;
    q = rounded[40:16];
    res = raw[15] ? 32'(-{7'd0, q}) : {7'd0, q};
    case (kind)
      KIND_MAG:  scale_word = {raw, 16'd0};
      KIND_TIME: scale_word = '0;
      default:   scale_word = res;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/imufps_parser.sv =====
// Byte parser: header hunt, frame collection and frame register.
`timescale 1ns / 1ps
`default_nettype none

module imufps_parser
  import imufps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  input  wire logic             cfg_valid,
  input  wire logic [LEN_W-1:0] cfg_data,
  output logic                  frame_valid,
  input  wire logic             frame_ready,
  output frame_t                frame
);

  logic [LEN_W-1:0] frame_length;
  logic [LEN_W-1:0] eff_len;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       frame_type;
  logic [7:0]       frame_type_next;
  payload_t         payload;
  payload_t         payload_next;
  logic             done;
  logic             known;
  logic [2:0]       kind;
  logic             accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !frame_valid || frame_ready;

  always_comb begin
    if (frame_length < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (frame_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = frame_length;
    end
  end

  always_comb begin
    pos_next        = pos;
    frame_type_next = frame_type;
    payload_next    = payload;
    done            = 1'b0;
    if (pos == '0) begin
      if (in_data.data_byte == HEADER_BYTE) begin
        pos_next = POS_W'(1);
      end
    end else begin
      if (pos == POS_W'(1)) begin
        frame_type_next = in_data.data_byte;
      end
      if (pos >= POS_W'(2) && pos < POS_W'(10)) begin
        payload_next[3'(pos - POS_W'(2))] = in_data.data_byte;
      end
      if (({1'b0, pos} + LEN_W'(1)) >= eff_len) begin
        done     = 1'b1;
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
    if (in_data.end_of_burst) begin
      pos_next = '0;
    end
  end

  always_comb begin
    known = 1'b1;
    case (frame_type)
      TYPE_TIME:  kind = KIND_TIME;
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_GYRO:  kind = KIND_GYRO;
      TYPE_ANGLE: kind = KIND_ANGLE;
      TYPE_MAG:   kind = KIND_MAG;
      TYPE_QUAT:  kind = KIND_QUAT;
      default: begin
        kind  = KIND_TIME;
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= LEN_RESET;
      pos          <= '0;
      frame_type   <= '0;
      frame_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_length <= cfg_data;
      end
      if (frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (accept) begin
        pos        <= pos_next;
        frame_type <= frame_type_next;
        if (done && known) begin
          frame_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      payload <= payload_next;
      if (done && known) begin
        frame.kind    <= kind;
        frame.payload <= payload_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/imufps_scaler.sv =====
// Word assembly, Q16.16 scaling and result register.
`timescale 1ns / 1ps
`default_nettype none

module imufps_scaler
  import imufps_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   frame_valid,
  output logic        frame_ready,
  input  wire frame_t frame,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_t        out_data
);

  logic [3:0][15:0] words;
  out_t             result;

  assign frame_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      words[i] = {frame.payload[2 * i + 1], frame.payload[2 * i]};
    end
    result.kind      = frame.kind;
    result.raw_word0 = words[0];
    result.raw_word1 = words[1];
    result.raw_word2 = words[2];
    result.raw_word3 = words[3];
    result.scaled0   = scale_word(words[0], frame.kind);
    result.scaled1   = scale_word(words[1], frame.kind);
    result.scaled2   = scale_word(words[2], frame.kind);
    result.scaled3   = (frame.kind == KIND_QUAT) ? scale_word(words[3], frame.kind) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/imu_frame_parser_scaler.sv =====
// IMU serial frame parser with Q16.16 scaling: top level.
//
// Input channel (in_valid/in_ready/in_data) takes one serial byte per
// transaction with an end-of-burst flag. The parser hunts for header 0x55,
// then collects a frame of frame_length bytes (clamped to 10..32).
// A complete known-type frame yields one output transaction carrying the kind,
// four raw signed words and their Q16.16 scaled values (the fourth only for
// quaternions); unknown types yield nothing. End of burst drops a partial frame.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes frame_length;
// cfg_ready is always high. Write it only while the block is idle.
// Throughput: one byte per cycle while in_ready is high.
// Output path: the last frame byte completes the frame in the frame register,
// then the scaled result is captured in the result register.
// Stall: a held result backs up into the frame register; in_ready drops
// only when both hold a frame.
// Reset: frame_length returns to 11, the parser hunts, no result is valid.
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_parser_scaler
  import imufps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  assign cfg_ready = 1'b1;

  imufps_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  imufps_scaler u_scaler (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef ASSERT_OFF
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && frame_valid) |-> !in_ready)
    else $error("input accepted while both stages hold a frame");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kind <= KIND_QUAT))
    else $error("result kind out of range");

  a_fourth_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind != KIND_QUAT) |-> (out_data.scaled3 == '0))
    else $error("fourth scaled word nonzero outside quaternion");

  a_time_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_TIME) |-> (out_data.scaled0 == '0))
    else $error("time frame scaled nonzero");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/imu_frame_parser_scaler_tb.sv =====
// Self-checking testbench for imu_frame_parser_scaler: directed frames and random byte streams checked per frame.
`timescale 1ns / 1ps

module imu_frame_parser_scaler_tb;
  import imufps_pkg::*;

  localparam int unsigned TOTAL_BYTES = 1700;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint unsigned ACCEL_Q16 = 20552090;
  localparam longint unsigned GYRO_Q16 = 4575276;
  localparam longint unsigned ANGLE_Q16 = 411775;
  localparam longint unsigned QUAT_Q16 = 131072;
  localparam longint unsigned MAG_Q16 = 64'd1 << 32;

  class imu_frame_scoreboard;
    logic [LEN_W-1:0] frame_length;
    int unsigned byte_pos;
    logic [7:0] frame_type;
    logic [7:0] payload [8];
    out_t pending_frames [$];
    int unsigned errors;
    int unsigned frames_checked;

    function new();
      frame_length = LEN_RESET;
      byte_pos = 0;
      frame_type = '0;
      foreach (payload[i]) payload[i] = '0;
      errors = 0;
      frames_checked = 0;
    endfunction

    function int unsigned frame_bytes();
      if (frame_length < LEN_MIN) return MIN_FRAME_LENGTH;
      if (frame_length > LEN_MAX) return MAX_FRAME_LENGTH;
      return int'(frame_length);
    endfunction

    function logic [31:0] scale_q16(logic signed [15:0] raw, longint unsigned mult);
      int w;
      longint unsigned mag;
      longint unsigned q;
      w = raw;
      mag = (w < 0) ? -w : w;
      q = (mag * mult + 64'h8000) >> 16;
      if (w < 0) q = -q;
      return q[31:0];
    endfunction

    function void finish_frame();
      out_t exp;
      longint unsigned mult;
      logic [15:0] w [4];
      exp = '0;
      case (frame_type)
        TYPE_TIME: begin
          exp.kind = KIND_TIME;
          mult = 0;
        end
        TYPE_ACCEL: begin
          exp.kind = KIND_ACCEL;
          mult = ACCEL_Q16;
        end
        TYPE_GYRO: begin
          exp.kind = KIND_GYRO;
          mult = GYRO_Q16;
        end
        TYPE_ANGLE: begin
          exp.kind = KIND_ANGLE;
          mult = ANGLE_Q16;
        end
        TYPE_MAG: begin
          exp.kind = KIND_MAG;
          mult = MAG_Q16;
        end
        TYPE_QUAT: begin
          exp.kind = KIND_QUAT;
          mult = QUAT_Q16;
        end
        default: return;
      endcase
      for (int i = 0; i < 4; i++) w[i] = {payload[2*i+1], payload[2*i]};
      exp.raw_word0 = w[0];
      exp.raw_word1 = w[1];
      exp.raw_word2 = w[2];
      exp.raw_word3 = w[3];
      exp.scaled0 = scale_q16(w[0], mult);
      exp.scaled1 = scale_q16(w[1], mult);
      exp.scaled2 = scale_q16(w[2], mult);
      exp.scaled3 = (exp.kind == KIND_QUAT) ? scale_q16(w[3], mult) : '0;
      pending_frames = {pending_frames, exp};
    endfunction

    function void note_byte(in_t item);
      if (byte_pos == 0) begin
        if (item.data_byte == HEADER_BYTE) byte_pos = 1;
      end else begin
        if (byte_pos == 1) frame_type = item.data_byte;
        else if (byte_pos < 10) payload[byte_pos - 2] = item.data_byte;
        if (byte_pos + 1 >= frame_bytes()) begin
          finish_frame();
          byte_pos = 0;
        end else begin
          byte_pos++;
        end
      end
      if (item.end_of_burst) byte_pos = 0;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending_frames.pop_front();
      frames_checked++;
      compare("kind", exp.kind, got.kind);
      compare("raw_word0", exp.raw_word0, got.raw_word0);
      compare("raw_word1", exp.raw_word1, got.raw_word1);
      compare("raw_word2", exp.raw_word2, got.raw_word2);
      compare("raw_word3", exp.raw_word3, got.raw_word3);
      compare("scaled0", exp.scaled0, got.scaled0);
      compare("scaled1", exp.scaled1, got.scaled1);
      compare("scaled2", exp.scaled2, got.scaled2);
      compare("scaled3", exp.scaled3, got.scaled3);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  bit quiet = 1'b0;
  bit gaps_on = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 1;
  imu_frame_scoreboard sb;

  imu_frame_parser_scaler i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if (!quiet) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic eob);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: value, end_of_burst: eob};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // words[15:0] is the first payload word, low byte first on the wire
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] words,
                            input int eob_at, input int cut);
    logic [7:0] wire_bytes [MAX_FRAME_LENGTH];
    int len;
    len = int'(sb.frame_bytes());
    wire_bytes[0] = HEADER_BYTE;
    wire_bytes[1] = ftype;
    for (int i = 2; i < MAX_FRAME_LENGTH; i++) wire_bytes[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) wire_bytes[i + 2] = words[8*i +: 8];
    for (int i = 0; i < len && i < cut; i++) send_byte(wire_bytes[i], i == eob_at);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 8))
      0: return TYPE_TIME;
      1: return TYPE_ACCEL;
      2: return TYPE_GYRO;
      3: return TYPE_ANGLE;
      4: return TYPE_MAG;
      5: return TYPE_QUAT;
      6: return HEADER_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    int len;
    int eob_at;
    int cut;
    len = sb.frame_bytes();
    gaps_on = $urandom_range(0, 3) != 0;
    eob_at = -1;
    cut = len;
    case ($urandom_range(0, 19))
      0, 1: eob_at = $urandom_range(0, len - 2);
      2, 3: eob_at = len - 1;
      4: cut = $urandom_range(1, len - 1);
      5: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      default: ;
    endcase
    send_frame(pick_type(), {pick_word(), pick_word(), pick_word(), pick_word()},
               eob_at, cut);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.frame_length = value;
    settings_used++;
  endtask

  function automatic logic [LEN_W-1:0] length_for_phase(input int p);
    case (p)
      1: return 6'd10;
      2: return 6'd32;
      3: return 6'd0;
      4: return 6'd63;
      5: return 6'd9;
      6: return 6'd33;
      7: return 6'd21;
      default: return 6'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase_end;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_frame(TYPE_TIME, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, -1, 255);
    send_frame(TYPE_ACCEL, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 10, 255);
    send_frame(TYPE_GYRO, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, -1, 255);
    send_frame(TYPE_ANGLE, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, -1, 255);
    send_frame(TYPE_MAG, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, -1, 255);
    send_frame(TYPE_QUAT, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}, -1, 255);
    send_frame(8'h00, {4{16'h1234}}, -1, 255);
    send_frame(TYPE_ACCEL, {4{16'h5555}}, -1, 255);
    send_frame(TYPE_GYRO, {4{16'hA5A5}}, 5, 255);
    send_frame(HEADER_BYTE, {4{16'h0F0F}}, -1, 255);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_length(length_for_phase(p));
      end
      quiet = (p == NUM_PHASES - 1);
      phase_end = bytes_sent + TOTAL_BYTES / NUM_PHASES;
      while (bytes_sent < phase_end) send_random_frame();
    end

    drain();
    $display("run covered %0d bytes under %0d frame-length settings", bytes_sent,
             settings_used);
    $display("%0d frames compared field by field", sb.frames_checked);
    if (sb.errors == 0) $display("imu_frame_parser_scaler_tb: clean");
    else $display("imu_frame_parser_scaler_tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("imu_frame_parser_scaler_tb: errors");
    $finish;
  end

endmodule
